// ===== rtl/swad_pkg.sv =====
package swad_pkg;

    localparam int ACTION_W    = 2;
    localparam int LETTER_W    = 5;
    localparam int LETTER_SPAN = 1 << LETTER_W;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NOP,
        OP_PATTERN,
        OP_TEXT,
        OP_CLEAR
    } swad_op_kind_t;

    typedef struct packed {
        swad_op_kind_t         kind;
        logic [LETTER_W-1:0]   letter;
    } swad_op_t;

endpackage

// ===== rtl/swad_if.sv =====
interface swad_in_if import swad_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink   (input valid, input action, input letter, output ready);
endinterface

interface swad_out_if import swad_pkg::*; ();
    logic valid;
    logic ready;
    logic window_full;
    logic match;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output window_full, output match, output found,
                    output pattern_overflow, input ready);
    modport sink   (input valid, input window_full, input match, input found,
                    input pattern_overflow, output ready);
endinterface

// ===== rtl/swad_front.sv =====
module swad_front import swad_pkg::*; #(
    parameter int ALPHABET = 26
) (
    swad_in_if.sink  cmd,
    output logic     push_valid,
    input  logic     push_ready,
    output swad_op_t push_op
);

    logic letter_ok;

    // letter must index the alphabet; wide compare covers alphabets past 32
    assign letter_ok = ({{(9 - LETTER_W){1'b0}}, cmd.letter} < 9'(ALPHABET));

    always_comb
    begin
        push_op.letter = cmd.letter;
        case (cmd.action)
            ACT_PATTERN: push_op.kind = letter_ok ? OP_PATTERN : OP_NOP;
            ACT_TEXT:    push_op.kind = letter_ok ? OP_TEXT : OP_NOP;
            ACT_CLEAR:   push_op.kind = OP_CLEAR;
            default:     push_op.kind = OP_NOP;
        endcase
    end

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;

endmodule

// ===== rtl/swad_queue.sv =====
module swad_queue import swad_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  swad_op_t push_op,
    output logic     pop_valid,
    input  logic     pop_ready,
    output swad_op_t pop_op
);

    swad_op_t         slot_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/swad_back.sv =====
module swad_back import swad_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  swad_op_t    pop_op,
    swad_out_if.source  rsp
);

    localparam int NL = (ALPHABET < LETTER_SPAN) ? ALPHABET : LETTER_SPAN;
    localparam int LW = $clog2(NL);
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int MW = $clog2(NL + 1);

    logic [CW-1:0]       pc_reg [NL];
    logic [CW-1:0]       pc_next [NL];
    logic [CW-1:0]       wc_reg [NL];
    logic [CW-1:0]       wc_next [NL];
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [MW-1:0]       nz_reg, nz_next;
    logic [MW-1:0]       mis_reg, mis_next;
    logic                found_reg, found_next;

    logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
    logic [LETTER_W-1:0] old_reg;
    logic [PW-1:0]       ring_raddr;
    logic                ring_we;

    logic                rsp_valid_reg;
    logic                full_reg, match_reg, found_out_reg, ovf_reg;

    logic                take;
    logic                evict;
    logic                match;
    logic                overflow;
    logic [LW-1:0]       l_idx, old_idx;
    logic [CW-1:0]       c_old, c_old_dn, p_old;
    logic [CW-1:0]       c_new, c_new_up, p_new;
    logic [CW-1:0]       ptr_inc;
    logic [MW-1:0]       mis_mid, mis_txt;

    assign take      = pop_valid && (!rsp_valid_reg || rsp.ready);
    assign pop_ready = take;

    assign l_idx   = pop_op.letter[LW-1:0];
    assign old_idx = old_reg[LW-1:0];

    always_comb
    begin
        pc_next    = pc_reg;
        wc_next    = wc_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        nz_next    = nz_reg;
        mis_next   = mis_reg;
        found_next = found_reg;
        ring_we    = 1'b0;
        match      = 1'b0;
        overflow   = 1'b0;

        // evict the oldest letter once the window is full
        evict    = (fill_reg == len_reg);
        p_old    = pc_reg[old_idx];
        c_old    = wc_reg[old_idx];
        c_old_dn = (c_old != '0) ? c_old - CW'(1) : c_old;
        mis_mid  = evict ? mis_reg + MW'(c_old == p_old) - MW'(c_old_dn == p_old) : mis_reg;

        c_new    = (evict && (old_idx == l_idx)) ? c_old_dn : wc_reg[l_idx];
        p_new    = pc_reg[l_idx];
        c_new_up = c_new + CW'(1);
        mis_txt  = mis_mid + MW'(c_new == p_new) - MW'(c_new_up == p_new);

        ptr_inc  = CW'(ptr_reg) + CW'(1);

        case (pop_op.kind)
            OP_CLEAR:
            begin
                pc_next    = '{default: '0};
                wc_next    = '{default: '0};
                len_next   = '0;
                fill_next  = '0;
                ptr_next   = '0;
                nz_next    = '0;
                mis_next   = '0;
                found_next = 1'b0;
            end
            OP_PATTERN:
            begin
                if (len_reg == CW'(MAX_PATTERN))
                begin
                    overflow = 1'b1;
                end
                else
                begin
                    pc_next[l_idx] = pc_reg[l_idx] + CW'(1);
                    len_next       = len_reg + CW'(1);
                    nz_next        = nz_reg + MW'(pc_reg[l_idx] == '0);
                end
                wc_next    = '{default: '0};
                fill_next  = '0;
                ptr_next   = '0;
                mis_next   = nz_next;
                found_next = 1'b0;
            end
            OP_TEXT:
            begin
                if (len_reg != '0)
                begin
                    if (evict)
                    begin
                        wc_next[old_idx] = c_old_dn;
                    end
                    else
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    wc_next[l_idx] = c_new_up;
                    mis_next       = mis_txt;
                    ring_we        = 1'b1;
                    ptr_next       = (ptr_inc >= len_reg) ? '0 : PW'(ptr_inc);
                end
                if ((fill_next == len_reg) && (mis_next == '0))
                begin
                    match      = 1'b1;
                    found_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '{default: '0};
            wc_reg        <= '{default: '0};
            len_reg       <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            nz_reg        <= '0;
            mis_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pc_reg    <= pc_next;
                wc_reg    <= wc_next;
                len_reg   <= len_next;
                fill_reg  <= fill_next;
                ptr_reg   <= ptr_next;
                nz_reg    <= nz_next;
                mis_reg   <= mis_next;
                found_reg <= found_next;
            end
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // prefetch the entry at the next pointer; bypass a same-cycle write
    assign ring_raddr = take ? ptr_next : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (take && ring_we)
        begin
            ring_mem[ptr_reg] <= pop_op.letter;
        end
        if (take && ring_we && (ptr_reg == ring_raddr))
        begin
            old_reg <= pop_op.letter;
        end
        else
        begin
            old_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            full_reg      <= (fill_next == len_next);
            match_reg     <= match;
            found_out_reg <= found_next;
            ovf_reg       <= overflow;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.window_full      = full_reg;
    assign rsp.match            = match_reg;
    assign rsp.found            = found_out_reg;
    assign rsp.pattern_overflow = ovf_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_reg)
        else $error("window fill exceeds pattern length");

    a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (CW'(ptr_reg) < len_reg))
        else $error("ring pointer outside window");

    a_empty_no_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> (mis_reg == '0))
        else $error("mismatch count nonzero with empty pattern");

    a_match_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && match_reg) |-> (full_reg && found_out_reg))
        else $error("match reported on a window that is not full");
`endif

endmodule

// ===== rtl/sliding_window_anagram_detector.sv =====
// Channel   Dir  Fields                                        Accepted when
// cmd       in   action[1:0], letter[4:0]                      cmd.valid && cmd.ready
// rsp       out  window_full, match, found, pattern_overflow   rsp.valid && rsp.ready
//
// One item per cycle sustained while rsp is ready; each item yields exactly one result item.
// A result is registered in two steps: the item is first written into the two-entry
// queue, and when the back end takes it from the queue the histogram update runs
// and the output register is loaded, so the result can then be taken from rsp.
// Reset (rst_n low, asynchronous) empties pattern, window and queue at once.
// A stalled rsp fills the queue, then drops cmd.ready; the update loop of the
// back end (histogram read, mismatch adjust, ring prefetch) sets the one-cycle rate.
module sliding_window_anagram_detector import swad_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    swad_in_if.sink    cmd,
    swad_out_if.source rsp
);

    logic     push_valid;
    logic     push_ready;
    swad_op_t push_op;
    logic     pop_valid;
    logic     pop_ready;
    swad_op_t pop_op;

    // Front: decode the action and drop out-of-range letters to a no-op.
    swad_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Queue: hold decoded items so the front keeps taking items while rsp stalls, until the queue is full.
    swad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back: update histograms, ring and mismatch count; register the result.
    swad_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .rsp       (rsp)
    );

endmodule

// ===== verif/tb_sliding_window_anagram_detector.sv =====
module tb_sliding_window_anagram_detector;
    import swad_pkg::*;

    localparam int MAXP        = 64;
    localparam int ALPHA       = 26;
    localparam int ITEM_TARGET = 1850;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Action code 3 has no name in the package; the block must ignore it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [LETTER_W-1:0] LTR_A      = 5'd0;
    localparam logic [LETTER_W-1:0] LTR_Z      = 5'd25;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LETTER_W-1:0] letter;
    } letter_item_t;

    typedef struct packed {
        logic window_full;
        logic match;
        logic found;
        logic pattern_overflow;
    } anagram_flags_t;

    logic clk = 1'b0;
    logic rst_n;

    swad_in_if  cmd_ch ();
    swad_out_if rsp_ch ();

    sliding_window_anagram_detector #(
        .MAX_PATTERN (MAXP),
        .ALPHABET    (ALPHA)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Items waiting to be sent, and flags the detector owes us, oldest first.
    letter_item_t   letter_feed [$];
    anagram_flags_t expected_flags [$];

    // Detector state as the design should hold it.
    logic [6:0]          pat_cnt [ALPHA];
    logic [6:0]          win_cnt [ALPHA];
    logic [LETTER_W-1:0] win_ring [MAXP];
    logic [6:0]          pat_len;
    logic [6:0]          win_fill;
    logic [5:0]          ring_ptr;
    logic [4:0]          diff_letters;
    logic                found_q;

    int  cycle_count    = 0;
    int  error_count    = 0;
    int  counted_items  = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  matches_seen   = 0;
    int  overflows_seen = 0;
    int  send_hold      = 0;
    int  stall_left     = 0;
    bit  feed_open      = 1'b0;
    bit  cmd_taken      = 1'b0;

    letter_item_t   send_item;
    anagram_flags_t seen_flags;
    anagram_flags_t want_flags;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Empty the text window; the mismatch count restarts at the number of
    // letters the pattern uses, since the window holds none of them.
    task automatic flush_window();
        win_fill     = '0;
        ring_ptr     = '0;
        found_q      = 1'b0;
        diff_letters = '0;
        for (int i = 0; i < MAXP; i++)
            win_ring[i] = '0;
        for (int i = 0; i < ALPHA; i++) begin
            win_cnt[i] = '0;
            if (pat_cnt[i] != 0)
                diff_letters++;
        end
    endtask

    task automatic reset_detector();
        for (int i = 0; i < ALPHA; i++)
            pat_cnt[i] = '0;
        pat_len = '0;
        flush_window();
    endtask

    // Move one window count up or down and keep the mismatch count in step.
    task automatic bump_window(input logic [LETTER_W-1:0] ltr, input bit up);
        if (win_cnt[ltr] == pat_cnt[ltr])
            diff_letters++;
        if (up)
            win_cnt[ltr]++;
        else if (win_cnt[ltr] != 0)
            win_cnt[ltr]--;
        if (win_cnt[ltr] == pat_cnt[ltr])
            diff_letters--;
    endtask

    task automatic advance_detector(input logic [ACTION_W-1:0] act,
                                    input logic [LETTER_W-1:0] ltr,
                                    output anagram_flags_t flags);
        logic [6:0] ptr_inc;
        logic       hit;
        logic       dropped;
        hit     = 1'b0;
        dropped = 1'b0;
        if (act == ACT_CLEAR) begin
            reset_detector();
        end else if ((act == ACT_PATTERN || act == ACT_TEXT) && ltr < ALPHA) begin
            if (act == ACT_PATTERN) begin
                // A full pattern drops the letter but still empties the window.
                if (pat_len >= MAXP) begin
                    dropped = 1'b1;
                end else begin
                    pat_cnt[ltr]++;
                    pat_len++;
                end
                flush_window();
            end else begin
                // Empty pattern: nothing to slide, every text letter matches.
                if (pat_len != 0) begin
                    if (win_fill == pat_len)
                        bump_window(win_ring[ring_ptr], 1'b0);
                    else
                        win_fill++;
                    bump_window(ltr, 1'b1);
                    win_ring[ring_ptr] = ltr;
                    ptr_inc  = {1'b0, ring_ptr} + 7'd1;
                    ring_ptr = (ptr_inc >= pat_len) ? 6'd0 : ptr_inc[5:0];
                end
                if (win_fill == pat_len && diff_letters == 0) begin
                    hit     = 1'b1;
                    found_q = 1'b1;
                end
            end
        end
        flags.window_full      = (win_fill == pat_len);
        flags.match            = hit;
        flags.found            = found_q;
        flags.pattern_overflow = dropped;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Queue one item; count it toward the target unless the block ignores it.
    task automatic push_item(input logic [ACTION_W-1:0] act,
                             input logic [LETTER_W-1:0] ltr);
        letter_item_t it;
        it.action = act;
        it.letter = ltr;
        letter_feed.push_back(it);
        if (act == ACT_CLEAR || (act != ACT_UNUSED && ltr < ALPHA))
            counted_items++;
    endtask

    // Occasional disturbance in a text stream: an item the block must ignore,
    // or a stray pattern letter that grows the pattern and breaks the window.
    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_item(ACT_TEXT, 5'($urandom_range(ALPHA, 31)));
            1: push_item(ACT_PATTERN, 5'($urandom_range(ALPHA, 31)));
            2: push_item(ACT_UNUSED, 5'($urandom_range(0, 31)));
            default: push_item(ACT_PATTERN, 5'($urandom_range(0, ALPHA - 1)));
        endcase
    endtask

    // One well-formed round: optional clear, a pattern drawn from a few
    // neighboring letters, then text made of shuffled copies of the pattern
    // and random runs mostly over the same letters.
    task automatic push_round(input int forced_len);
        logic [LETTER_W-1:0] pat [$];
        logic [LETTER_W-1:0] perm [$];
        logic [LETTER_W-1:0] ltr;
        logic [LETTER_W-1:0] tmp;
        int plen;
        int base;
        int span;
        int roll;
        int run;
        int j;
        if (forced_len == 0 && $urandom_range(0, 3) == 0)
            push_item(ACT_CLEAR, 5'($urandom_range(0, 31)));
        roll = $urandom_range(0, 99);
        if (forced_len != 0)
            plen = forced_len;
        else if (roll < 80)
            plen = $urandom_range(1, 6);
        else if (roll < 95)
            plen = $urandom_range(7, 20);
        else
            plen = $urandom_range(MAXP - 4, MAXP + 4);
        base = $urandom_range(0, ALPHA - 1);
        span = $urandom_range(1, 4);
        for (int i = 0; i < plen; i++) begin
            ltr = 5'((base + $urandom_range(0, span - 1)) % ALPHA);
            push_item(ACT_PATTERN, ltr);
            if (pat.size() < MAXP)
                pat.push_back(ltr);
        end
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 1) begin
                perm = pat;
                for (int i = perm.size() - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
            end else begin
                perm.delete();
                run = $urandom_range(1, pat.size() + 3);
                for (int i = 0; i < run; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        perm.push_back(5'($urandom_range(0, ALPHA - 1)));
                    else
                        perm.push_back(5'((base + $urandom_range(0, span - 1)) % ALPHA));
                end
            end
            foreach (perm[i]) begin
                push_item(ACT_TEXT, perm[i]);
                if ($urandom_range(0, 29) == 0)
                    push_noise();
            end
        end
    endtask

    // Idling runs in bursts, but not while cycle_count[7:6] is zero (one quarter of the time)
    // and not once QUIET_TAIL or fewer items are left to send.
    function automatic bit idling_allowed();
        return (cycle_count[7:6] != 2'd0) && (letter_feed.size() > QUIET_TAIL);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present items at the falling edge, advance on acceptance
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (rst_n && feed_open && (!cmd_ch.valid || cmd_taken)) begin
            cmd_taken = 1'b0;
            if (send_hold > 0) begin
                send_hold--;
                cmd_ch.valid <= 1'b0;
            end else if (letter_feed.size() == 0) begin
                cmd_ch.valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                // Valid goes low here and stays low while send_hold counts down.
                send_hold = $urandom_range(0, 2);
                cmd_ch.valid <= 1'b0;
            end else begin
                send_item = letter_feed.pop_front();
                cmd_ch.valid  <= 1'b1;
                cmd_ch.action <= send_item.action;
                cmd_ch.letter <= send_item.letter;
            end
        end
    end

    // Result side back-pressure, in random bursts set by stall_left.
    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, check every accepted result
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n) begin
            cycle_count++;
            if (cmd_ch.valid && cmd_ch.ready) begin
                advance_detector(cmd_ch.action, cmd_ch.letter, want_flags);
                expected_flags.push_back(want_flags);
                items_accepted++;
                cmd_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                seen_flags.window_full      = rsp_ch.window_full;
                seen_flags.match            = rsp_ch.match;
                seen_flags.found            = rsp_ch.found;
                seen_flags.pattern_overflow = rsp_ch.pattern_overflow;
                if (expected_flags.size() == 0) begin
                    $error("result item with no item outstanding: %b", seen_flags);
                    error_count++;
                end else begin
                    want_flags = expected_flags.pop_front();
                    matches_seen   += want_flags.match;
                    overflows_seen += want_flags.pattern_overflow;
                    if (seen_flags.window_full !== want_flags.window_full) begin
                        $error("window_full: expected %b, actual %b",
                               want_flags.window_full, seen_flags.window_full);
                        error_count++;
                    end
                    if (seen_flags.match !== want_flags.match) begin
                        $error("match: expected %b, actual %b",
                               want_flags.match, seen_flags.match);
                        error_count++;
                    end
                    if (seen_flags.found !== want_flags.found) begin
                        $error("found: expected %b, actual %b",
                               want_flags.found, seen_flags.found);
                        error_count++;
                    end
                    if (seen_flags.pattern_overflow !== want_flags.pattern_overflow) begin
                        $error("pattern_overflow: expected %b, actual %b",
                               want_flags.pattern_overflow, seen_flags.pattern_overflow);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hard stop if the design hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, build stimulus, run, drain, report
    // ------------------------------------------------------------------

    initial begin
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = ACT_PATTERN;
        cmd_ch.letter = '0;
        rsp_ch.ready  = 1'b0;
        reset_detector();

        // Empty pattern: text letters match at once.
        push_item(ACT_TEXT, LTR_A);
        push_item(ACT_TEXT, LTR_Z);
        // Out-of-range letters and the unused action code are ignored.
        push_item(ACT_TEXT, 5'd31);
        push_item(ACT_TEXT, 5'd26);
        push_item(ACT_PATTERN, 5'd27);
        push_item(ACT_UNUSED, 5'd5);
        push_item(ACT_UNUSED, 5'd31);
        // Pattern "az", then slide over "zaaz": match, miss, match.
        push_item(ACT_PATTERN, LTR_A);
        push_item(ACT_PATTERN, LTR_Z);
        push_item(ACT_TEXT, LTR_Z);
        push_item(ACT_TEXT, LTR_A);
        push_item(ACT_TEXT, LTR_A);
        push_item(ACT_TEXT, LTR_Z);
        push_item(ACT_TEXT, 5'd30);
        // A pattern letter mid-text empties the window and drops found.
        push_item(ACT_PATTERN, 5'd1);
        push_item(ACT_TEXT, 5'd1);
        push_item(ACT_TEXT, LTR_A);
        push_item(ACT_TEXT, LTR_Z);
        // Clear, then the empty-pattern match again.
        push_item(ACT_CLEAR, 5'd31);
        push_item(ACT_TEXT, 5'd1);
        push_item(ACT_PATTERN, 5'd2);
        push_item(ACT_TEXT, 5'd3);
        push_item(ACT_CLEAR, LTR_A);

        // Start random rounds with a pattern past capacity so dropped letters
        // and a full-length window show up early, then keep going.
        push_round(MAXP + 2);
        while (counted_items < ITEM_TARGET)
            push_round(0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        feed_open = 1'b1;

        // Hold until every item is sent and every result has come back.
        do
            @(negedge clk);
        while (letter_feed.size() != 0 || cmd_ch.valid || expected_flags.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Sent %0d items (ignored codes and letters included), checked %0d results",
                 items_accepted, results_seen);
        $display("Windows matched: %0d, pattern letters dropped at capacity: %0d",
                 matches_seen, overflows_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
